### sv/tsma_pkg.sv
// Shared types and field widths for the triple moving-average crossover unit.
// No dependencies; the files that use this package refer to it by scoped names.
`default_nettype none

package tsma_pkg;

    localparam int TIME_W  = 44;
    localparam int PRICE_W = 40;
    localparam int VOL_W   = 48;

    typedef struct packed {
        logic [TIME_W-1:0]  start_time;
        logic [PRICE_W-1:0] open_price;
        logic [PRICE_W-1:0] high_price;
        logic [PRICE_W-1:0] low_price;
        logic [PRICE_W-1:0] close_price;
        logic [VOL_W-1:0]   traded_volume;
    } candle_t;

    typedef struct packed {
        logic short_full;
        logic mid_full;
        logic long_full;
    } win_ok_t;

endpackage

`default_nettype wire

### sv/tsma_ram.sv
// Generic single-write, single-read memory with a registered read port.
// No dependencies.
`default_nettype none

module tsma_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 99,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/tsma_front.sv
// Front end: accepts candles, keeps the close history and the running window sums.
// Uses tsma_pkg and three tsma_ram copies of the history, one per leaving tap.
`default_nettype none

module tsma_front #(
    parameter int SHORT_WINDOW = 7,
    parameter int MID_WINDOW   = 25,
    parameter int LONG_WINDOW  = 99,
    localparam int HIST  = (SHORT_WINDOW > MID_WINDOW)
                           ? ((SHORT_WINDOW > LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW)
                           : ((MID_WINDOW > LONG_WINDOW) ? MID_WINDOW : LONG_WINDOW),
    localparam int SW_S  = tsma_pkg::PRICE_W + $clog2(SHORT_WINDOW),
    localparam int SW_M  = tsma_pkg::PRICE_W + $clog2(MID_WINDOW),
    localparam int SW_L  = tsma_pkg::PRICE_W + $clog2(LONG_WINDOW)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tsma_pkg::candle_t     in_candle,
    output logic                  q_valid,
    input  logic                  q_ready,
    output tsma_pkg::candle_t     q_candle,
    output logic [SW_S-1:0]       q_sum_short,
    output logic [SW_M-1:0]       q_sum_mid,
    output logic [SW_L-1:0]       q_sum_long,
    output tsma_pkg::win_ok_t     q_ok
);

    localparam int PTR_W = $clog2(HIST);
    localparam int CNT_W = $clog2(HIST + 1);

    logic                      accept;
    logic                      advance;
    logic [PTR_W-1:0]          ptr_reg;
    logic [PTR_W-1:0]          ptr_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    tsma_pkg::candle_t         s1_candle_reg;
    tsma_pkg::win_ok_t         s1_ok_reg;
    tsma_pkg::win_ok_t         s1_old_ok_reg;
    tsma_pkg::win_ok_t         ok_next;
    tsma_pkg::win_ok_t         old_ok_next;
    logic [PTR_W-1:0]          addr_short;
    logic [PTR_W-1:0]          addr_mid;
    logic [PTR_W-1:0]          addr_long;
    logic [tsma_pkg::PRICE_W-1:0] old_short;
    logic [tsma_pkg::PRICE_W-1:0] old_mid;
    logic [tsma_pkg::PRICE_W-1:0] old_long;
    logic [SW_S-1:0]           sum_short_reg;
    logic [SW_S-1:0]           sum_short_next;
    logic [SW_M-1:0]           sum_mid_reg;
    logic [SW_M-1:0]           sum_mid_next;
    logic [SW_L-1:0]           sum_long_reg;
    logic [SW_L-1:0]           sum_long_next;

    function automatic logic [PTR_W-1:0] leave_addr(input logic [PTR_W-1:0] ptr, input int win);
        logic [PTR_W:0] p;
        logic [PTR_W:0] w;
        logic [PTR_W:0] h;
        p = {1'b0, ptr};
        w = (PTR_W+1)'(win);
        h = (PTR_W+1)'(HIST);
        if (p >= w)
            leave_addr = PTR_W'(p - w);
        else
            leave_addr = PTR_W'(p + h - w);
    endfunction

    assign in_ready = !s1_valid_reg || q_ready;
    assign accept   = in_valid && in_ready;
    assign advance  = s1_valid_reg && q_ready;

    assign addr_short = leave_addr(ptr_reg, SHORT_WINDOW);
    assign addr_mid   = leave_addr(ptr_reg, MID_WINDOW);
    assign addr_long  = leave_addr(ptr_reg, LONG_WINDOW);

    tsma_ram #(.WIDTH(tsma_pkg::PRICE_W), .DEPTH(HIST)) u_hist_short (
        .clk   (clk),
        .we    (accept),
        .waddr (ptr_reg),
        .wdata (in_candle.close_price),
        .re    (accept),
        .raddr (addr_short),
        .rdata (old_short)
    );

    tsma_ram #(.WIDTH(tsma_pkg::PRICE_W), .DEPTH(HIST)) u_hist_mid (
        .clk   (clk),
        .we    (accept),
        .waddr (ptr_reg),
        .wdata (in_candle.close_price),
        .re    (accept),
        .raddr (addr_mid),
        .rdata (old_mid)
    );

    tsma_ram #(.WIDTH(tsma_pkg::PRICE_W), .DEPTH(HIST)) u_hist_long (
        .clk   (clk),
        .we    (accept),
        .waddr (ptr_reg),
        .wdata (in_candle.close_price),
        .re    (accept),
        .raddr (addr_long),
        .rdata (old_long)
    );

    always_comb
    begin
        ptr_next      = ptr_reg;
        count_next    = count_reg;
        s1_valid_next = s1_valid_reg;
        if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
            ptr_next = (ptr_reg == PTR_W'(HIST - 1)) ? '0 : ptr_reg + 1'b1;
            if (count_reg != CNT_W'(HIST))
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // A history slot's value is only subtracted once it has been written, which the fill count tells.
    always_comb
    begin
        old_ok_next.short_full = count_reg >= CNT_W'(SHORT_WINDOW);
        old_ok_next.mid_full   = count_reg >= CNT_W'(MID_WINDOW);
        old_ok_next.long_full  = count_reg >= CNT_W'(LONG_WINDOW);
        ok_next.short_full     = count_next >= CNT_W'(SHORT_WINDOW);
        ok_next.mid_full       = count_next >= CNT_W'(MID_WINDOW);
        ok_next.long_full      = count_next >= CNT_W'(LONG_WINDOW);
    end

    always_comb
    begin
        sum_short_next = SW_S'({1'b0, sum_short_reg}
                         + (SW_S+1)'(s1_candle_reg.close_price)
                         - (SW_S+1)'(s1_old_ok_reg.short_full ? old_short : '0));
        sum_mid_next   = SW_M'({1'b0, sum_mid_reg}
                         + (SW_M+1)'(s1_candle_reg.close_price)
                         - (SW_M+1)'(s1_old_ok_reg.mid_full ? old_mid : '0));
        sum_long_next  = SW_L'({1'b0, sum_long_reg}
                         + (SW_L+1)'(s1_candle_reg.close_price)
                         - (SW_L+1)'(s1_old_ok_reg.long_full ? old_long : '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            sum_short_reg <= '0;
            sum_mid_reg   <= '0;
            sum_long_reg  <= '0;
        end
        else
        begin
            ptr_reg      <= ptr_next;
            count_reg    <= count_next;
            s1_valid_reg <= s1_valid_next;
            if (advance)
            begin
                sum_short_reg <= sum_short_next;
                sum_mid_reg   <= sum_mid_next;
                sum_long_reg  <= sum_long_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_candle_reg <= in_candle;
            s1_ok_reg     <= ok_next;
            s1_old_ok_reg <= old_ok_next;
        end
    end

    assign q_valid     = s1_valid_reg;
    assign q_candle    = s1_candle_reg;
    assign q_sum_short = sum_short_next;
    assign q_sum_mid   = sum_mid_next;
    assign q_sum_long  = sum_long_next;
    assign q_ok        = s1_ok_reg;

endmodule

`default_nettype wire

### sv/tsma_fifo.sv
// Short queue that decouples the front end from the averaging back end.
// No dependencies.
`default_nettype none

module tsma_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg != CW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

### sv/tsma_div.sv
// Two-stage exact division of a window sum by a constant window length.
// Uses tsma_pkg; the reciprocal product is split into four narrow partial products.
`default_nettype none

module tsma_div #(
    parameter int DIVISOR = 7,
    localparam int SW = tsma_pkg::PRICE_W + $clog2(DIVISOR)
) (
    input  logic                         clk,
    input  logic                         en_a,
    input  logic                         en_b,
    input  logic [SW-1:0]                sum,
    output logic [tsma_pkg::PRICE_W-1:0] quot
);

    localparam int L  = $clog2(DIVISOR);
    localparam int SH = SW + L;
    localparam int MW = SW + 1;
    localparam int PW = SW + MW;
    localparam int NL = (SW + 1) / 2;
    localparam int NH = SW - NL;
    localparam int ML = (MW + 1) / 2;
    localparam int MH = MW - ML;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0] RECIP = RECIP64[MW-1:0];

    logic [NL+ML-1:0]              p_ll_next;
    logic [NL+MH-1:0]              p_lh_next;
    logic [NH+ML-1:0]              p_hl_next;
    logic [NH+MH-1:0]              p_hh_next;
    logic [NL+ML-1:0]              p_ll_reg;
    logic [NL+MH-1:0]              p_lh_reg;
    logic [NH+ML-1:0]              p_hl_reg;
    logic [NH+MH-1:0]              p_hh_reg;
    logic [PW-1:0]                 product;
    logic [tsma_pkg::PRICE_W-1:0]  quot_next;
    logic [tsma_pkg::PRICE_W-1:0]  quot_reg;

    assign p_ll_next = (NL+ML)'(sum[NL-1:0])  * (NL+ML)'(RECIP[ML-1:0]);
    assign p_lh_next = (NL+MH)'(sum[NL-1:0])  * (NL+MH)'(RECIP[MW-1:ML]);
    assign p_hl_next = (NH+ML)'(sum[SW-1:NL]) * (NH+ML)'(RECIP[ML-1:0]);
    assign p_hh_next = (NH+MH)'(sum[SW-1:NL]) * (NH+MH)'(RECIP[MW-1:ML]);

    assign product = PW'(p_ll_reg)
                   + (PW'(p_lh_reg) << ML)
                   + (PW'(p_hl_reg) << NL)
                   + (PW'(p_hh_reg) << (NL + ML));
    assign quot_next = product[SH +: tsma_pkg::PRICE_W];

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            p_ll_reg <= p_ll_next;
            p_lh_reg <= p_lh_next;
            p_hl_reg <= p_hl_next;
            p_hh_reg <= p_hh_next;
        end
        if (en_b)
        begin
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

`default_nettype wire

### sv/tsma_back.sv
// Back end: divides the three window sums, forms the buy flag and holds the result.
// Uses tsma_pkg and three tsma_div lanes.
`default_nettype none

module tsma_back #(
    parameter int SHORT_WINDOW = 7,
    parameter int MID_WINDOW   = 25,
    parameter int LONG_WINDOW  = 99,
    localparam int SW_S = tsma_pkg::PRICE_W + $clog2(SHORT_WINDOW),
    localparam int SW_M = tsma_pkg::PRICE_W + $clog2(MID_WINDOW),
    localparam int SW_L = tsma_pkg::PRICE_W + $clog2(LONG_WINDOW)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  tsma_pkg::candle_t            in_candle,
    input  logic [SW_S-1:0]              in_sum_short,
    input  logic [SW_M-1:0]              in_sum_mid,
    input  logic [SW_L-1:0]              in_sum_long,
    input  tsma_pkg::win_ok_t            in_ok,
    output logic                         out_valid,
    input  logic                         out_ready,
    output tsma_pkg::candle_t            out_candle,
    output logic [tsma_pkg::PRICE_W-1:0] avg_short,
    output logic [tsma_pkg::PRICE_W-1:0] avg_mid,
    output logic [tsma_pkg::PRICE_W-1:0] avg_long,
    output logic                         buy_signal
);

    logic                         load_a;
    logic                         load_b;
    logic                         load_o;
    logic                         a_valid_reg;
    logic                         a_valid_next;
    logic                         b_valid_reg;
    logic                         b_valid_next;
    logic                         o_valid_reg;
    logic                         o_valid_next;
    tsma_pkg::candle_t            a_candle_reg;
    tsma_pkg::candle_t            b_candle_reg;
    tsma_pkg::candle_t            o_candle_reg;
    tsma_pkg::win_ok_t            a_ok_reg;
    tsma_pkg::win_ok_t            b_ok_reg;
    logic [tsma_pkg::PRICE_W-1:0] quot_short;
    logic [tsma_pkg::PRICE_W-1:0] quot_mid;
    logic [tsma_pkg::PRICE_W-1:0] quot_long;
    logic [tsma_pkg::PRICE_W-1:0] avg_short_next;
    logic [tsma_pkg::PRICE_W-1:0] avg_mid_next;
    logic [tsma_pkg::PRICE_W-1:0] avg_long_next;
    logic                         buy_next;
    logic [tsma_pkg::PRICE_W-1:0] avg_short_reg;
    logic [tsma_pkg::PRICE_W-1:0] avg_mid_reg;
    logic [tsma_pkg::PRICE_W-1:0] avg_long_reg;
    logic                         buy_reg;

    assign load_o   = !o_valid_reg || out_ready;
    assign load_b   = !b_valid_reg || load_o;
    assign load_a   = !a_valid_reg || load_b;
    assign in_ready = load_a;

    tsma_div #(.DIVISOR(SHORT_WINDOW)) u_div_short (
        .clk  (clk),
        .en_a (load_a && in_valid),
        .en_b (load_b && a_valid_reg),
        .sum  (in_sum_short),
        .quot (quot_short)
    );

    tsma_div #(.DIVISOR(MID_WINDOW)) u_div_mid (
        .clk  (clk),
        .en_a (load_a && in_valid),
        .en_b (load_b && a_valid_reg),
        .sum  (in_sum_mid),
        .quot (quot_mid)
    );

    tsma_div #(.DIVISOR(LONG_WINDOW)) u_div_long (
        .clk  (clk),
        .en_a (load_a && in_valid),
        .en_b (load_b && a_valid_reg),
        .sum  (in_sum_long),
        .quot (quot_long)
    );

    // An average whose window is not yet full reads as zero, and the flag sees that zero.
    always_comb
    begin
        avg_short_next = b_ok_reg.short_full ? quot_short : '0;
        avg_mid_next   = b_ok_reg.mid_full   ? quot_mid   : '0;
        avg_long_next  = b_ok_reg.long_full  ? quot_long  : '0;
        buy_next       = (avg_short_next > avg_mid_next) && (avg_short_next > avg_long_next);
        a_valid_next   = load_a ? in_valid    : a_valid_reg;
        b_valid_next   = load_b ? a_valid_reg : b_valid_reg;
        o_valid_next   = load_o ? b_valid_reg : o_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_a && in_valid)
        begin
            a_candle_reg <= in_candle;
            a_ok_reg     <= in_ok;
        end
        if (load_b && a_valid_reg)
        begin
            b_candle_reg <= a_candle_reg;
            b_ok_reg     <= a_ok_reg;
        end
        if (load_o && b_valid_reg)
        begin
            o_candle_reg  <= b_candle_reg;
            avg_short_reg <= avg_short_next;
            avg_mid_reg   <= avg_mid_next;
            avg_long_reg  <= avg_long_next;
            buy_reg       <= buy_next;
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_candle = o_candle_reg;
    assign avg_short  = avg_short_reg;
    assign avg_mid    = avg_mid_reg;
    assign avg_long   = avg_long_reg;
    assign buy_signal = buy_reg;

endmodule

`default_nettype wire

### sv/triple_sma_crossover_unit.sv
// Top level of the triple moving-average crossover unit.
// Uses tsma_pkg, tsma_front, tsma_fifo and tsma_back.
//
// Channel   Handshake                 Payload
// input     in_valid / in_ready       start_time, open/high/low/close_price, traded_volume
// result    out_valid / out_ready     out_* copies, avg_short/mid/long, buy_signal
//
// One candle is taken every cycle while the result side keeps up.
// A result passes through the front register, the queue, two divider stages and the output
// register; the running-sum update in the front end sets the candle rate.
// Reset clears the history fill count, pointers, sums and all valid flags; no clearing pass.
// A stalled result fills the back end first and then the queue before in_ready drops.
`default_nettype none

module triple_sma_crossover_unit #(
    parameter int SHORT_WINDOW = 7,
    parameter int MID_WINDOW   = 25,
    parameter int LONG_WINDOW  = 99,
    parameter int QUEUE_DEPTH  = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tsma_pkg::TIME_W-1:0]  start_time,
    input  logic [tsma_pkg::PRICE_W-1:0] open_price,
    input  logic [tsma_pkg::PRICE_W-1:0] high_price,
    input  logic [tsma_pkg::PRICE_W-1:0] low_price,
    input  logic [tsma_pkg::PRICE_W-1:0] close_price,
    input  logic [tsma_pkg::VOL_W-1:0]   traded_volume,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tsma_pkg::TIME_W-1:0]  out_start_time,
    output logic [tsma_pkg::PRICE_W-1:0] out_open,
    output logic [tsma_pkg::PRICE_W-1:0] out_high,
    output logic [tsma_pkg::PRICE_W-1:0] out_low,
    output logic [tsma_pkg::PRICE_W-1:0] out_close,
    output logic [tsma_pkg::VOL_W-1:0]   out_volume,
    output logic [tsma_pkg::PRICE_W-1:0] avg_short,
    output logic [tsma_pkg::PRICE_W-1:0] avg_mid,
    output logic [tsma_pkg::PRICE_W-1:0] avg_long,
    output logic                         buy_signal
);

    localparam int SW_S = tsma_pkg::PRICE_W + $clog2(SHORT_WINDOW);
    localparam int SW_M = tsma_pkg::PRICE_W + $clog2(MID_WINDOW);
    localparam int SW_L = tsma_pkg::PRICE_W + $clog2(LONG_WINDOW);

    typedef struct packed {
        tsma_pkg::candle_t candle;
        logic [SW_S-1:0]   sum_short;
        logic [SW_M-1:0]   sum_mid;
        logic [SW_L-1:0]   sum_long;
        tsma_pkg::win_ok_t ok;
    } q_entry_t;

    tsma_pkg::candle_t in_candle;
    tsma_pkg::candle_t res_candle;
    q_entry_t          q_wr;
    q_entry_t          q_rd;
    logic              q_wr_valid;
    logic              q_wr_ready;
    logic              q_rd_valid;
    logic              q_rd_ready;

    always_comb
    begin
        in_candle.start_time    = start_time;
        in_candle.open_price    = open_price;
        in_candle.high_price    = high_price;
        in_candle.low_price     = low_price;
        in_candle.close_price   = close_price;
        in_candle.traded_volume = traded_volume;
    end

    tsma_front #(
        .SHORT_WINDOW (SHORT_WINDOW),
        .MID_WINDOW   (MID_WINDOW),
        .LONG_WINDOW  (LONG_WINDOW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_candle   (in_candle),
        .q_valid     (q_wr_valid),
        .q_ready     (q_wr_ready),
        .q_candle    (q_wr.candle),
        .q_sum_short (q_wr.sum_short),
        .q_sum_mid   (q_wr.sum_mid),
        .q_sum_long  (q_wr.sum_long),
        .q_ok        (q_wr.ok)
    );

    tsma_fifo #(
        .WIDTH ($bits(q_entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_wr_valid),
        .in_ready  (q_wr_ready),
        .in_data   (q_wr),
        .out_valid (q_rd_valid),
        .out_ready (q_rd_ready),
        .out_data  (q_rd)
    );

    tsma_back #(
        .SHORT_WINDOW (SHORT_WINDOW),
        .MID_WINDOW   (MID_WINDOW),
        .LONG_WINDOW  (LONG_WINDOW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (q_rd_valid),
        .in_ready     (q_rd_ready),
        .in_candle    (q_rd.candle),
        .in_sum_short (q_rd.sum_short),
        .in_sum_mid   (q_rd.sum_mid),
        .in_sum_long  (q_rd.sum_long),
        .in_ok        (q_rd.ok),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_candle   (res_candle),
        .avg_short    (avg_short),
        .avg_mid      (avg_mid),
        .avg_long     (avg_long),
        .buy_signal   (buy_signal)
    );

    assign out_start_time = res_candle.start_time;
    assign out_open       = res_candle.open_price;
    assign out_high       = res_candle.high_price;
    assign out_low        = res_candle.low_price;
    assign out_close      = res_candle.close_price;
    assign out_volume     = res_candle.traded_volume;

endmodule

`default_nettype wire

### dv/tsma_checker.sv
// Checker for the triple moving-average crossover unit: predicts every result beat from the
// accepted candles and compares it field by field. Depends on tsma_pkg for types and widths.
module tsma_checker #(
    parameter int SHORT_WINDOW = 7,
    parameter int MID_WINDOW   = 25,
    parameter int LONG_WINDOW  = 99
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [tsma_pkg::TIME_W-1:0]  start_time,
    input  logic [tsma_pkg::PRICE_W-1:0] open_price,
    input  logic [tsma_pkg::PRICE_W-1:0] high_price,
    input  logic [tsma_pkg::PRICE_W-1:0] low_price,
    input  logic [tsma_pkg::PRICE_W-1:0] close_price,
    input  logic [tsma_pkg::VOL_W-1:0]   traded_volume,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [tsma_pkg::TIME_W-1:0]  out_start_time,
    input  logic [tsma_pkg::PRICE_W-1:0] out_open,
    input  logic [tsma_pkg::PRICE_W-1:0] out_high,
    input  logic [tsma_pkg::PRICE_W-1:0] out_low,
    input  logic [tsma_pkg::PRICE_W-1:0] out_close,
    input  logic [tsma_pkg::VOL_W-1:0]   out_volume,
    input  logic [tsma_pkg::PRICE_W-1:0] avg_short,
    input  logic [tsma_pkg::PRICE_W-1:0] avg_mid,
    input  logic [tsma_pkg::PRICE_W-1:0] avg_long,
    input  logic                         buy_signal,
    output int                           mismatches,
    output int                           outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW = tsma_pkg::PRICE_W;
    localparam int SPAN_SM = (MID_WINDOW > SHORT_WINDOW) ? MID_WINDOW : SHORT_WINDOW;
    localparam int SPAN = (LONG_WINDOW > SPAN_SM) ? LONG_WINDOW : SPAN_SM;

    typedef struct {
        tsma_pkg::candle_t bar;
        logic [PW-1:0]     avg_short;
        logic [PW-1:0]     avg_mid;
        logic [PW-1:0]     avg_long;
        logic              buy;
    } bar_result_t;

    logic [PW-1:0] close_ring [SPAN];
    logic [63:0]   sum_short;
    logic [63:0]   sum_mid;
    logic [63:0]   sum_long;
    int            seen;
    int            ring_slot;
    bar_result_t   predicted_bars [$];

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic roll_windows(input tsma_pkg::candle_t c, output bar_result_t r);
        logic [63:0] q_s;
        logic [63:0] q_m;
        logic [63:0] q_l;
        sum_short = sum_short + 64'(c.close_price)
                    - 64'(close_ring[(ring_slot + SPAN - SHORT_WINDOW) % SPAN]);
        sum_mid   = sum_mid + 64'(c.close_price)
                    - 64'(close_ring[(ring_slot + SPAN - MID_WINDOW) % SPAN]);
        sum_long  = sum_long + 64'(c.close_price)
                    - 64'(close_ring[(ring_slot + SPAN - LONG_WINDOW) % SPAN]);
        close_ring[ring_slot] = c.close_price;
        ring_slot = (ring_slot + 1) % SPAN;
        if (seen < SPAN)
            seen++;
        q_s = (seen < SHORT_WINDOW) ? 64'd0 : sum_short / 64'(SHORT_WINDOW);
        q_m = (seen < MID_WINDOW) ? 64'd0 : sum_mid / 64'(MID_WINDOW);
        q_l = (seen < LONG_WINDOW) ? 64'd0 : sum_long / 64'(LONG_WINDOW);
        r.bar       = c;
        r.avg_short = q_s[PW-1:0];
        r.avg_mid   = q_m[PW-1:0];
        r.avg_long  = q_l[PW-1:0];
        r.buy       = (r.avg_short > r.avg_mid) && (r.avg_short > r.avg_long);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        tsma_pkg::candle_t c;
        bar_result_t       want;
        bar_result_t       made;
        if (!rst_n)
        begin
            for (int i = 0; i < SPAN; i++)
                close_ring[i] = '0;
            sum_short = '0;
            sum_mid = '0;
            sum_long = '0;
            seen = 0;
            ring_slot = 0;
            predicted_bars.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (predicted_bars.size() == 0)
                begin
                    $error("result beat with no candle waiting");
                    mismatches++;
                end
                else
                begin
                    want = predicted_bars.pop_front();
                    check_field("out_start_time", want.bar.start_time, out_start_time);
                    check_field("out_open", want.bar.open_price, out_open);
                    check_field("out_high", want.bar.high_price, out_high);
                    check_field("out_low", want.bar.low_price, out_low);
                    check_field("out_close", want.bar.close_price, out_close);
                    check_field("out_volume", want.bar.traded_volume, out_volume);
                    check_field("avg_short", want.avg_short, avg_short);
                    check_field("avg_mid", want.avg_mid, avg_mid);
                    check_field("avg_long", want.avg_long, avg_long);
                    check_field("buy_signal", want.buy, buy_signal);
                end
            end
            if (in_valid && in_ready)
            begin
                c.start_time    = start_time;
                c.open_price    = open_price;
                c.high_price    = high_price;
                c.low_price     = low_price;
                c.close_price   = close_price;
                c.traded_volume = traded_volume;
                roll_windows(c, made);
                predicted_bars.insert(predicted_bars.size(), made);
            end
            outstanding = predicted_bars.size();
        end
    end

endmodule

### dv/tb_triple_sma_crossover_unit.sv
// Testbench top for the triple moving-average crossover unit: drives candles and takes
// result beats with random gaps, and gives the verdict. Depends on tsma_pkg and tsma_checker.
module tb_triple_sma_crossover_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PW        = tsma_pkg::PRICE_W;
    localparam int          TW        = tsma_pkg::TIME_W;
    localparam int          VW        = tsma_pkg::VOL_W;
    localparam logic [63:0] PRICE_MAX = (64'd1 << PW) - 64'd1;
    localparam int          RANDOM_CANDLES = 950;

    typedef enum int {DRIFT_UP, DRIFT_DOWN, WIDE_SWING, PINNED_TOP, PINNED_FLOOR, CHOP}
        tape_mode_t;

    logic                         clk;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic [tsma_pkg::TIME_W-1:0]  start_time = '0;
    logic [PW-1:0]                open_price = '0;
    logic [PW-1:0]                high_price = '0;
    logic [PW-1:0]                low_price = '0;
    logic [PW-1:0]                close_price = '0;
    logic [tsma_pkg::VOL_W-1:0]   traded_volume = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [tsma_pkg::TIME_W-1:0]  out_start_time;
    logic [PW-1:0]                out_open;
    logic [PW-1:0]                out_high;
    logic [PW-1:0]                out_low;
    logic [PW-1:0]                out_close;
    logic [tsma_pkg::VOL_W-1:0]   out_volume;
    logic [PW-1:0]                avg_short;
    logic [PW-1:0]                avg_mid;
    logic [PW-1:0]                avg_long;
    logic                         buy_signal;
    int                           mismatches;
    int                           outstanding;

    int send_left = 0;
    bit send_calm = 1'b0;
    int take_left = 0;
    bit take_calm = 1'b0;

    triple_sma_crossover_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .start_time     (start_time),
        .open_price     (open_price),
        .high_price     (high_price),
        .low_price      (low_price),
        .close_price    (close_price),
        .traded_volume  (traded_volume),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_start_time (out_start_time),
        .out_open       (out_open),
        .out_high       (out_high),
        .out_low        (out_low),
        .out_close      (out_close),
        .out_volume     (out_volume),
        .avg_short      (avg_short),
        .avg_mid        (avg_mid),
        .avg_long       (avg_long),
        .buy_signal     (buy_signal)
    );

    tsma_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .start_time     (start_time),
        .open_price     (open_price),
        .high_price     (high_price),
        .low_price      (low_price),
        .close_price    (close_price),
        .traded_volume  (traded_volume),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_start_time (out_start_time),
        .out_open       (out_open),
        .out_high       (out_high),
        .out_low        (out_low),
        .out_close      (out_close),
        .out_volume     (out_volume),
        .avg_short      (avg_short),
        .avg_mid        (avg_mid),
        .avg_long       (avg_long),
        .buy_signal     (buy_signal),
        .mismatches     (mismatches),
        .outstanding    (outstanding)
    );

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Gaps come in stretches, some of which have no gaps at all.
    function automatic int draw_wait(inout int left, inout bit calm);
        if (left == 0)
        begin
            left = $urandom_range(8, 60);
            calm = ($urandom_range(0, 3) == 0);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    task automatic offer_candle(input tsma_pkg::candle_t c);
        int gap;
        gap = draw_wait(send_left, send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        start_time    <= c.start_time;
        open_price    <= c.open_price;
        high_price    <= c.high_price;
        low_price     <= c.low_price;
        close_price   <= c.close_price;
        traded_volume <= c.traded_volume;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin : take_results
        int gap;
        forever
        begin
            gap = draw_wait(take_left, take_calm);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin : make_candles
        tsma_pkg::candle_t c;
        logic [255:0]      pat;
        logic [63:0]       px;
        logic [63:0]       step;
        tape_mode_t        mode;
        int                seg_len;
        int                sent;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes first; the run of full-scale closes fills the short window well before
        // the longer ones, so the buy flag must rise during warm-up.
        pat = {32{8'h55}};
        for (int n = 0; n < 25; n++)
        begin
            c.start_time    = TW'(rand_word());
            c.open_price    = PW'(rand_word());
            c.high_price    = PW'(rand_word());
            c.low_price     = PW'(rand_word());
            c.close_price   = PW'(rand_word());
            c.traded_volume = VW'(rand_word());
            if (n == 0)
                c = '0;
            else if (n == 1)
                c = '1;
            else if (n <= 9)
                c.close_price = '1;
            else if (n == 10)
                c = pat[$bits(tsma_pkg::candle_t)-1:0];
            else if (n == 11)
                c = ~pat[$bits(tsma_pkg::candle_t)-1:0];
            else
                c.close_price = {16'd0, 8'(n), 16'd0};
            offer_candle(c);
        end

        px = rand_word() & PRICE_MAX;
        sent = 0;
        while (sent < RANDOM_CANDLES)
        begin
            mode = tape_mode_t'($urandom_range(0, 5));
            if (mode == PINNED_TOP || mode == PINNED_FLOOR)
                seg_len = $urandom_range(100, 140);
            else
                seg_len = $urandom_range(10, 160);
            step = (64'd1 << $urandom_range(1, 36)) - 64'd1;
            for (int k = 0; k < seg_len && sent < RANDOM_CANDLES; k++)
            begin
                case (mode)
                    DRIFT_UP:
                        px = px + (rand_word() & step);
                    DRIFT_DOWN:
                        px = (px < (rand_word() & step)) ? 64'd0 : px - (rand_word() & step);
                    WIDE_SWING:
                        px = rand_word();
                    PINNED_TOP:
                        px = PRICE_MAX - (($urandom_range(0, 3) == 0) ?
                                          64'($urandom_range(0, 255)) : 64'd0);
                    PINNED_FLOOR:
                        px = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 255)) : 64'd0;
                    default:
                        if ($urandom_range(0, 1) == 1)
                            px = px + (rand_word() & step);
                        else
                            px = (px < (rand_word() & step)) ? 64'd0 : px - (rand_word() & step);
                endcase
                if (px > PRICE_MAX)
                    px = (mode == WIDE_SWING) ? (px & PRICE_MAX) : PRICE_MAX;
                c.start_time    = TW'(rand_word());
                c.open_price    = PW'(rand_word());
                c.high_price    = PW'(rand_word());
                c.low_price     = PW'(rand_word());
                c.close_price   = px[PW-1:0];
                c.traded_volume = VW'(rand_word());
                offer_candle(c);
                sent++;
            end
        end
        in_valid <= 1'b0;

        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
